/* rtl/bdq_pkg.sv */
// Shared constants, codes, types and ring index helpers for the bounded deque.
// No dependencies; imported by all bdq modules.
package bdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
  localparam logic [2:0] OP_FIND       = 3'd6;
  localparam logic [2:0] OP_REMOVE     = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
  } mem_req_t;

  // ring position of logical entry k counted from base
  function automatic logic [AW-1:0] slot_f(logic [AW-1:0] base, logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] dec_f(logic [AW-1:0] base);
    logic [AW-1:0] r;
    if (base == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = base - AW'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/bounded_deque_with_match.sv */
// Bounded deque with masked match: sequencer, ring pointers, result register.
// Push writes on accept unless full; pop/peek read one entry unless empty; find scans
// to the first hit; remove also shifts each later entry one slot toward the front. The
// next accept follows loading the output reg. Scan and shifting use the single read port.
// Reset (async, active low) empties the deque and sets the match mask to all ones.
// Depends on bdq_pkg, bdq_mem, bdq_cmp.
module bounded_deque_with_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] data_out_o,
  output logic [1:0]  status_o,
  output logic [4:0]  fill_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import bdq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         issue_k_q, issue_k_d;
  logic [CW-1:0]         cmp_k_q, cmp_k_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [CW-1:0]         sh_k_q, sh_k_d;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [31:0]           mask_q;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_data_q;
  logic [1:0]            out_status_q;
  logic [4:0]            out_count_q;
  logic                  out_load;

  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  hit;
  logic [CW:0]           sh_next;

  bdq_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  bdq_cmp u_cmp (
    .entry_i (rd_data),
    .key_i   (key_q),
    .mask_i  (DATA_WIDTH'(mask_q)),
    .hit_o   (hit)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign sh_next     = (CW+1)'(sh_k_q) + (CW+1)'(1);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    front_d      = front_q;
    count_d      = count_q;
    issue_k_d    = issue_k_q;
    cmp_k_d      = cmp_k_q;
    rd_vld_d     = 1'b0;
    sh_k_d       = sh_k_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    mem_req      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_i;
          key_d        = DATA_WIDTH'(value_i);
          res_data_d   = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          case (op_i)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = DATA_WIDTH'(value_i);
                count_d         = count_q + CW'(1);
                if (op_i == OP_PUSH_FRONT) begin
                  front_d         = dec_f(front_q);
                  mem_req.wr_addr = dec_f(front_q);
                end else begin
                  mem_req.wr_addr = slot_f(front_q, count_q);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                mem_req.rd_en = 1'b1;
                if (op_i == OP_POP_FRONT || op_i == OP_PEEK_FRONT) begin
                  mem_req.rd_addr = front_q;
                end else begin
                  mem_req.rd_addr = slot_f(front_q, count_q - CW'(1));
                end
                state_d = S_READ;
              end
            end
            default: begin
              issue_k_d = '0;
              state_d   = S_SCAN;
            end
          endcase
        end
      end
      S_READ: begin
        res_data_d = rd_data;
        if (op_q == OP_POP_FRONT) begin
          front_d = slot_f(front_q, CW'(1));
          count_d = count_q - CW'(1);
        end else if (op_q == OP_POP_BACK) begin
          count_d = count_q - CW'(1);
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (rd_vld_q && hit) begin
          res_data_d = rd_data;
          if (op_q == OP_REMOVE) begin
            sh_k_d  = cmp_k_q;
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (issue_k_q < count_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = slot_f(front_q, issue_k_q);
          rd_vld_d        = 1'b1;
          cmp_k_d         = issue_k_q;
          issue_k_d       = issue_k_q + CW'(1);
        end else begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end
      end
      S_SHIFT_RD: begin
        if (sh_next < (CW+1)'(count_q)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = slot_f(front_q, sh_next[CW-1:0]);
          state_d         = S_SHIFT_WR;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = slot_f(front_q, sh_k_q);
        mem_req.wr_data = rd_data;
        sh_k_d          = sh_next[CW-1:0];
        state_d         = S_SHIFT_RD;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      issue_k_q   <= '0;
      rd_vld_q    <= 1'b0;
      mask_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      issue_k_q   <= issue_k_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    cmp_k_q      <= cmp_k_d;
    sh_k_q       <= sh_k_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_data_q   <= 32'(res_data_q);
      out_status_q <= res_status_q;
      out_count_q  <= 5'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_data_q;
  assign status_o     = out_status_q;
  assign fill_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready while a transaction is in progress");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> fill_count_o == 5'(DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> fill_count_o == '0)
    else $error("empty status with nonzero count");

endmodule

/* rtl/bdq_mem.sv */
// Entry storage: one write port, one registered read port.
// Depends on bdq_pkg.
module bdq_mem (
  input  logic                           clk_i,
  input  bdq_pkg::mem_req_t              req_i,
  output logic [bdq_pkg::DATA_WIDTH-1:0] rd_data_o
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/bdq_cmp.sv */
// Masked equality compare shared by find and remove scans.
// Depends on bdq_pkg.
module bdq_cmp (
  input  logic [bdq_pkg::DATA_WIDTH-1:0] entry_i,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] key_i,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] mask_i,
  output logic                           hit_o
);
  import bdq_pkg::*;

  assign hit_o = ((entry_i ^ key_i) & mask_i) == '0;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_with_match: a deque mirror predicts each result.
// Random ops, mask settings, bursty sender and stalling receiver. Depends on bdq_pkg and the RTL.
module tb_top;
  import bdq_pkg::*;

  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 228;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct {
    logic [31:0] data;
    logic [1:0]  status;
    logic [4:0]  fill;
  } result_t;

  class deque_mirror;
    logic [DATA_WIDTH-1:0] ring [DEPTH];
    int unsigned head;
    int unsigned fill;
    logic [31:0] mask;
    result_t due[$];
    int mismatches;
    int checked;
    int mask_writes;
    int op_seen [8];
    int status_seen [4];

    function new();
      head = 0;
      fill = 0;
      mask = '1;
      mismatches = 0;
      checked = 0;
      mask_writes = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned at(int unsigned k);
      return (head + k) % DEPTH;
    endfunction

    function void set_mask(logic [31:0] m);
      mask = m;
      mask_writes++;
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    function bit locate(logic [31:0] key, output int unsigned pos);
      pos = 0;
      for (int unsigned k = 0; k < fill; k++) begin
        if (((ring[at(k)] ^ key) & mask) == '0) begin
          pos = k;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void apply_request(logic [2:0] op, logic [31:0] v);
      result_t r;
      int unsigned p;
      r.data = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else if (op == OP_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = v;
            fill++;
          end else begin
            ring[at(fill)] = v;
            fill++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) r.data = ring[head];
            else r.data = ring[at(fill - 1)];
            if (op == OP_POP_FRONT) begin
              head = at(1);
              fill--;
            end else if (op == OP_POP_BACK) begin
              fill--;
            end
          end
        end
        OP_FIND: begin
          if (locate(v, p)) r.data = ring[at(p)];
          else r.status = ST_NOT_FOUND;
        end
        default: begin
          if (locate(v, p)) begin
            r.data = ring[at(p)];
            for (int unsigned k = p; k + 1 < fill; k++) ring[at(k)] = ring[at(k + 1)];
            fill--;
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
      endcase
      r.fill = 5'(fill);
      op_seen[op]++;
      status_seen[r.status]++;
      due.push_back(r);
    endfunction

    function void compare_result(logic [31:0] d, logic [1:0] s, logic [4:0] c);
      result_t e;
      checked++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: data %h status %0d count %0d", d, s, c);
        return;
      end
      e = due.pop_front();
      if (d !== e.data || s !== e.status || c !== e.fill) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: data %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                   e.data, d, e.status, s, e.fill, c);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  op_i;
  logic [31:0] value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] data_out_o;
  logic [1:0]  status_o;
  logic [4:0]  fill_count_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;

  deque_mirror sb;
  bit filling = 1'b1;
  bit hold_req = 1'b0;
  int unsigned stall_cycles = 0;

  always #1 clk_i = ~clk_i;

  bounded_deque_with_match u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.apply_request(op_i, value_i);
      if (out_valid_o && out_ready_i) sb.compare_result(data_out_o, status_o, fill_count_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_mask(cfg_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  // receiver: segments of differing stall patterns, plus one long hold-off on request
  initial begin
    int seg_len;
    int mode;
    int cyc;
    out_ready_i = 1'b0;
    cyc = 0;
    forever begin
      seg_len = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk_i);
        cyc++;
        if (hold_req) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= (cyc % 5) != 0;
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 7);
    if (r == 4) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (r == 5) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic void pick_request(output logic [2:0] op, output logic [31:0] v);
    int w_push;
    int w_pop;
    int r;
    int unsigned k;
    if (sb.fill == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
    else if (sb.fill == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    else if ($urandom_range(0, 39) == 0) filling = !filling;
    w_push = filling ? 6 : 2;
    w_pop = filling ? 1 : 4;
    r = $urandom_range(0, w_push + w_pop + 4);
    if (r < w_push) op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    else if (r < w_push + w_pop) op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    else if (r < w_push + w_pop + 1) op = $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
    else if (r < w_push + w_pop + 3) op = OP_FIND;
    else op = OP_REMOVE;
    if ((op == OP_FIND || op == OP_REMOVE) && sb.fill > 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, sb.fill - 1);
      v = sb.ring[sb.at(k)] ^ ($urandom & ~sb.mask);
      if ($urandom_range(0, 4) == 0) v ^= 32'h1 << $urandom_range(0, 31);
    end else begin
      v = rand_word();
    end
  endfunction

  // call at a falling edge; returns right after the accepting rising edge
  task automatic offer(input logic [2:0] op, input logic [31:0] v);
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_fixed(input logic [2:0] op, input logic [31:0] v);
    @(negedge clk_i);
    offer(op, v);
  endtask

  task automatic send_random();
    logic [2:0] op;
    logic [31:0] v;
    @(negedge clk_i);
    pick_request(op, v);
    offer(op, v);
  endtask

  task automatic idle(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic write_mask(input logic [31:0] m);
    drain();
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] masks [PHASES];
    int burst_left;
    in_valid_i = 1'b0;
    op_i = OP_PUSH_FRONT;
    value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queue: every read-type op, and find/remove with nothing held
    send_fixed(OP_POP_FRONT, 32'h0);
    send_fixed(OP_POP_BACK, 32'hFFFF_FFFF);
    send_fixed(OP_PEEK_FRONT, 32'h0);
    send_fixed(OP_PEEK_BACK, 32'h0);
    send_fixed(OP_FIND, 32'h0);
    send_fixed(OP_REMOVE, 32'h0);
    // fill to capacity from both ends, then push when full
    send_fixed(OP_PUSH_BACK, 32'h0);
    send_fixed(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) begin
      send_fixed(i % 2 ? OP_PUSH_FRONT : OP_PUSH_BACK,
                 i == 0 ? 32'hA5A5_A5A5 : i == 1 ? 32'h5A5A_5A5A : 32'h1 << (2 * i + 3));
    end
    send_fixed(OP_PUSH_FRONT, 32'h1234_5678);
    send_fixed(OP_PUSH_BACK, 32'h8765_4321);
    send_fixed(OP_PEEK_FRONT, 32'h0);
    send_fixed(OP_PEEK_BACK, 32'h0);
    send_fixed(OP_FIND, 32'h5A5A_5A5A);
    send_fixed(OP_REMOVE, 32'hA5A5_A5A5);
    send_fixed(OP_FIND, 32'hA5A5_A5A5);
    send_fixed(OP_POP_FRONT, 32'h0);
    send_fixed(OP_POP_BACK, 32'h0);

    masks[0] = 32'hFFFF_FFFF;
    masks[1] = 32'h0000_0000;
    masks[2] = 32'h0000_FFFF;
    masks[3] = 32'hFFFF_0000;
    masks[4] = 32'h0000_0007;
    masks[5] = 32'h8000_0000;
    masks[6] = $urandom;
    masks[7] = 32'hFFFF_FFFF;
    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_mask(masks[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
        end
        burst_left--;
        if (p == 2 && i == 100) hold_req = 1'b1;
        if (p == 4 && i == 120) drain();
        send_random();
      end
    end
    drain();
    repeat (40) @(negedge clk_i);

    $display("covered: %0d results over %0d masks; push f/b %0d/%0d, pop f/b %0d/%0d,",
             sb.checked, sb.mask_writes,
             sb.op_seen[OP_PUSH_FRONT], sb.op_seen[OP_PUSH_BACK],
             sb.op_seen[OP_POP_FRONT], sb.op_seen[OP_POP_BACK]);
    $display("  peek f/b %0d/%0d, find %0d, remove %0d; ok %0d empty %0d full %0d miss %0d",
             sb.op_seen[OP_PEEK_FRONT], sb.op_seen[OP_PEEK_BACK],
             sb.op_seen[OP_FIND], sb.op_seen[OP_REMOVE],
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
             sb.status_seen[ST_NOT_FOUND]);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.outstanding());
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
